// ----- rtl/pda_pkg.sv -----
// ---------------------------------------------------------------------------
// pda_pkg
// Shared types, codes and helpers of the pushdown automaton recognizer.
// ---------------------------------------------------------------------------
package pda_pkg;

  localparam int NUM_STATES  = 16;
  localparam int NUM_SYMBOLS = 16;
  localparam int MAX_PUSH    = 4;
  localparam int STACK_DEPTH = 64;

  localparam int CODE_W  = 4;
  localparam int KEY_W   = 3 * CODE_W;
  localparam int TABLE_N = NUM_STATES * NUM_SYMBOLS * NUM_SYMBOLS;
  localparam int RULE_W  = 24;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_SYM   = 2'd2;
  localparam logic [1:0] OP_END   = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_ACCEPT   = 3'd1;
  localparam logic [2:0] ST_REJECT   = 3'd2;
  localparam logic [2:0] ST_BADSYM   = 3'd3;
  localparam logic [2:0] ST_STEPLIM  = 3'd4;
  localparam logic [2:0] ST_OVERFLOW = 3'd5;
  localparam logic [2:0] ST_STOPPED  = 3'd6;

  localparam logic [2:0] REG_INIT_STATE = 3'd0;
  localparam logic [2:0] REG_START_SYM  = 3'd1;
  localparam logic [2:0] REG_FINAL_MASK = 3'd2;
  localparam logic [2:0] REG_ALPHA_MASK = 3'd3;
  localparam logic [2:0] REG_STEP_LIMIT = 3'd4;

  localparam logic [CODE_W-1:0] BLANK_CODE = '0;

  typedef struct packed {
    logic              valid;
    logic [CODE_W-1:0] next;
    logic [2:0]        count;
    logic [15:0]       syms;
  } rule_t;

  // push symbol i of a rule, zero beyond the 16-bit field
  function automatic logic [CODE_W-1:0] push_nib(logic [15:0] syms, logic [2:0] i);
    logic [CODE_W-1:0] r;
    case (i)
      3'd0:    r = syms[3:0];
      3'd1:    r = syms[7:4];
      3'd2:    r = syms[11:8];
      3'd3:    r = syms[15:12];
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/pda_if.sv -----
// ---------------------------------------------------------------------------
// pda_if
// Valid/ready channels of the recognizer: request items and result items.
// ---------------------------------------------------------------------------
interface pda_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [3:0]  symbol;
  logic [3:0]  rule_state;
  logic [3:0]  rule_input;
  logic [3:0]  rule_top;
  logic [3:0]  rule_next;
  logic [2:0]  rule_push_count;
  logic [15:0] rule_push_symbols;
  logic        rule_valid;

  modport source (output valid, op, symbol, rule_state, rule_input, rule_top, rule_next,
                  rule_push_count, rule_push_symbols, rule_valid, input ready);
  modport sink   (input valid, op, symbol, rule_state, rule_input, rule_top, rule_next,
                  rule_push_count, rule_push_symbols, rule_valid, output ready);
endinterface

interface pda_result_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [3:0] state;
  logic [6:0] stack_depth;

  modport source (output valid, status, state, stack_depth, input ready);
  modport sink   (input valid, status, state, stack_depth, output ready);
endinterface

// ----- rtl/pushdown_automaton_recognizer.sv -----
// ---------------------------------------------------------------------------
// pushdown_automaton_recognizer
// Table-driven deterministic pushdown automaton with rule and stack memories.
// ---------------------------------------------------------------------------
// Usage: requests arrive on item (valid/ready). op load writes one rule into
// the 4096-entry rule memory, op start resets state and stack, op symbol
// feeds one input symbol, op end asks for accept or reject. Every request
// gives exactly one result on result (status, state, stack depth).
// Configuration goes through the APB port at byte address 4*i.
// Sequence: a load, start or refused request goes from idle straight to the
// done state, which registers its result; the next request is taken once
// the sequencer is back in idle. A symbol reads its consuming rule in eval
// and checks it in lookc; without one, the blank rule is checked in lookb.
// A rule that fires writes its pushes in push through the single stack
// write port, one push per cycle; a blank move then returns to eval. End of
// input accepts in eval if the state is final; else lookb moves or rejects.
// One request is worked on at a time; the next is taken while the result
// still waits in the output register.
// Reset: the rule memory is cleared by a pass over all 4096 entries, one entry per
// cycle, with item.ready low; configuration writes are taken meanwhile.
// When result is stalled the finished request holds until it is taken.
// ---------------------------------------------------------------------------
module pushdown_automaton_recognizer #(
  parameter int STACK_DEPTH = pda_pkg::STACK_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  pda_item_if.sink     item,
  pda_result_if.source result,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import pda_pkg::*;

  localparam int SPW  = $clog2(STACK_DEPTH + 1);
  localparam int SPW1 = SPW + 1;
  localparam int AW   = $clog2(STACK_DEPTH);
  localparam int CLRW = KEY_W + 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EVAL = 3'd1;
  localparam logic [2:0] S_LOOKC = 3'd2;
  localparam logic [2:0] S_LOOKB = 3'd3;
  localparam logic [2:0] S_PUSH = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  // configuration
  logic [3:0]  init_state, start_sym;
  logic [15:0] final_mask, alpha_mask, step_limit;

  // automaton
  logic [2:0]     st;
  logic [CLRW-1:0] clr_cnt;
  logic           clearing;
  logic [3:0]     astate, top;
  logic [SPW-1:0] sp, pbase;
  logic           stopped;
  logic [1:0]     it_op;
  logic [3:0]     it_sym;
  logic [15:0]    moves;
  logic [2:0]     idx;
  logic           blank_move;
  logic [2:0]     status;

  // memories
  logic [RULE_W-1:0] rule_mem [TABLE_N];
  logic [3:0]        stack_mem [STACK_DEPTH];
  rule_t             rq;
  logic [3:0]        sk_q;

  logic              rt_we, rt_re, sk_we, sk_re;
  logic [KEY_W-1:0]  rt_waddr, rt_raddr;
  rule_t             rt_wdata;
  logic [AW-1:0]     sk_waddr, sk_raddr;
  logic [3:0]        sk_wdata;

  logic           accept, is_final;
  logic [SPW-1:0] d_base;
  logic           ovf;
  logic [2:0]     sat_cnt;
  logic           fire_c, fire_b;

  assign clearing = !clr_cnt[CLRW-1];
  assign accept   = item.valid && item.ready;
  assign item.ready = (st == S_IDLE) && !clearing;
  assign is_final = final_mask[astate];
  assign d_base   = (sp != '0) ? sp - SPW'(1) : '0;
  assign ovf      = (SPW1'(d_base) + SPW1'(rq.count)) > SPW1'(STACK_DEPTH);
  assign sat_cnt  = (item.rule_push_count > 3'(MAX_PUSH)) ? 3'(MAX_PUSH)
                                                          : item.rule_push_count;
  assign fire_c   = (st == S_LOOKC) && rq.valid && !ovf;
  assign fire_b   = (st == S_LOOKB) && rq.valid && (moves < step_limit) && !ovf;

  always_comb begin
    rt_we    = 1'b0;
    rt_waddr = '0;
    rt_wdata = '0;
    rt_re    = 1'b0;
    rt_raddr = '0;
    sk_we    = 1'b0;
    sk_waddr = '0;
    sk_wdata = '0;
    sk_re    = 1'b0;
    sk_raddr = '0;
    if (clearing) begin
      rt_we    = 1'b1;
      rt_waddr = clr_cnt[KEY_W-1:0];
    end else if (accept && item.op == OP_LOAD) begin
      rt_we    = 1'b1;
      rt_waddr = {item.rule_state, item.rule_input, item.rule_top};
      rt_wdata = '{valid: item.rule_valid, next: item.rule_next, count: sat_cnt,
                   syms: item.rule_push_symbols};
    end
    if (accept && item.op == OP_START) begin
      sk_we    = 1'b1;
      sk_waddr = '0;
      sk_wdata = start_sym;
    end
    if (st == S_EVAL && !(it_op == OP_END && is_final)) begin
      rt_re    = 1'b1;
      rt_raddr = {astate, (it_op == OP_SYM) ? it_sym : BLANK_CODE, top};
    end
    if (st == S_LOOKC && !rq.valid) begin
      rt_re    = 1'b1;
      rt_raddr = {astate, BLANK_CODE, top};
    end
    // fetch the symbol below the popped top, needed when nothing is pushed
    if ((fire_c || fire_b) && d_base != '0) begin
      sk_re    = 1'b1;
      sk_raddr = AW'(d_base - SPW'(1));
    end
    if (st == S_PUSH && idx < rq.count) begin
      sk_we    = 1'b1;
      sk_waddr = AW'(pbase + SPW'(idx));
      sk_wdata = push_nib(rq.syms, idx);
    end
  end

  always_ff @(posedge clk) begin
    if (rt_we) begin
      rule_mem[rt_waddr] <= rt_wdata;
    end
    if (rt_re) begin
      rq <= rule_mem[rt_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (sk_we) begin
      stack_mem[sk_waddr] <= sk_wdata;
    end
    if (sk_re) begin
      sk_q <= stack_mem[sk_raddr];
    end
  end

  // configuration port
  assign pready = 1'b1;
  always_comb begin
    case (paddr[4:2])
      REG_INIT_STATE: prdata = {28'd0, init_state};
      REG_START_SYM:  prdata = {28'd0, start_sym};
      REG_FINAL_MASK: prdata = {16'd0, final_mask};
      REG_ALPHA_MASK: prdata = {16'd0, alpha_mask};
      REG_STEP_LIMIT: prdata = {16'd0, step_limit};
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      init_state <= 4'd0;
      start_sym  <= 4'd1;
      final_mask <= '0;
      alpha_mask <= '0;
      step_limit <= 16'd1024;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:2])
        REG_INIT_STATE: init_state <= pwdata[3:0];
        REG_START_SYM:  start_sym  <= pwdata[3:0];
        REG_FINAL_MASK: final_mask <= pwdata[15:0];
        REG_ALPHA_MASK: alpha_mask <= pwdata[15:0];
        REG_STEP_LIMIT: step_limit <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      st           <= S_IDLE;
      clr_cnt      <= '0;
      astate       <= '0;
      sp           <= '0;
      top          <= BLANK_CODE;
      stopped      <= 1'b1;
      result.valid <= 1'b0;
    end else begin
      if (clearing) begin
        clr_cnt <= clr_cnt + CLRW'(1);
      end
      // in S_DONE the output register is refilled instead
      if (result.valid && result.ready && st != S_DONE) begin
        result.valid <= 1'b0;
      end
      case (st)
        S_IDLE: begin
          if (accept) begin
            it_op  <= item.op;
            it_sym <= item.symbol;
            moves  <= '0;
            if (item.op == OP_LOAD) begin
              status <= ST_OK;
              st     <= S_DONE;
            end else if (item.op == OP_START) begin
              astate  <= init_state;
              sp      <= SPW'(1);
              top     <= start_sym;
              stopped <= 1'b0;
              status  <= ST_OK;
              st      <= S_DONE;
            end else if (stopped) begin
              status <= ST_STOPPED;
              st     <= S_DONE;
            end else if (item.op == OP_SYM &&
                         (item.symbol == BLANK_CODE || !alpha_mask[item.symbol])) begin
              status  <= ST_BADSYM;
              stopped <= 1'b1;
              st      <= S_DONE;
            end else begin
              st <= S_EVAL;
            end
          end
        end
        S_EVAL: begin
          if (it_op == OP_END && is_final) begin
            status  <= ST_ACCEPT;
            stopped <= 1'b1;
            st      <= S_DONE;
          end else begin
            st <= (it_op == OP_SYM) ? S_LOOKC : S_LOOKB;
          end
        end
        S_LOOKC: begin
          if (!rq.valid) begin
            st <= S_LOOKB;
          end else if (ovf) begin
            status  <= ST_OVERFLOW;
            stopped <= 1'b1;
            st      <= S_DONE;
          end else begin
            pbase      <= d_base;
            idx        <= '0;
            blank_move <= 1'b0;
            st         <= S_PUSH;
          end
        end
        S_LOOKB: begin
          if (!rq.valid) begin
            status  <= ST_REJECT;
            stopped <= 1'b1;
            st      <= S_DONE;
          end else if (moves >= step_limit) begin
            status  <= ST_STEPLIM;
            stopped <= 1'b1;
            st      <= S_DONE;
          end else if (ovf) begin
            status  <= ST_OVERFLOW;
            stopped <= 1'b1;
            st      <= S_DONE;
          end else begin
            pbase      <= d_base;
            idx        <= '0;
            blank_move <= 1'b1;
            st         <= S_PUSH;
          end
        end
        S_PUSH: begin
          if (idx < rq.count) begin
            idx <= idx + 3'd1;
          end else begin
            sp     <= pbase + SPW'(rq.count);
            astate <= rq.next;
            if (rq.count != 3'd0) begin
              top <= push_nib(rq.syms, rq.count - 3'd1);
            end else begin
              top <= (pbase != '0) ? sk_q : BLANK_CODE;
            end
            if (blank_move) begin
              moves <= moves + 16'd1;
              st    <= S_EVAL;
            end else begin
              status <= ST_OK;
              st     <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (!result.valid || result.ready) begin
            result.valid       <= 1'b1;
            result.status      <= status;
            result.state       <= astate;
            result.stack_depth <= 7'(sp);
            st                 <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !item.ready) else $error("request taken during rule clearing");

  a_sp_bound: assert property (@(posedge clk) disable iff (rst)
    sp <= SPW'(STACK_DEPTH)) else $error("stack pointer beyond depth");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> (st != S_IDLE)) else $error("sequencer idle after request");

  a_push_bound: assert property (@(posedge clk) disable iff (rst)
    (st == S_PUSH) |-> (idx <= rq.count)) else $error("push index past count");

endmodule

// ----- dv/pda_checker.sv -----
// ---------------------------------------------------------------------------
// pda_checker
// Watches the request, result and register ports of the recognizer, keeps
// its own copy of rule table, stack and automaton state, and compares every
// result with the predicted status, state and stack depth.
// ---------------------------------------------------------------------------
module pda_checker
  import pda_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  pda_item_if         item,
  pda_result_if       result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [2:0] status;
    logic [3:0] state;
    logic [6:0] depth;
  } outcome_t;

  rule_t       rules [TABLE_N];
  logic [3:0]  stk [STACK_DEPTH];
  int unsigned sp;
  logic [3:0]  cur;
  bit          halted;

  logic [3:0]  cfg_init_state;
  logic [3:0]  cfg_start_sym;
  logic [15:0] cfg_final;
  logic [15:0] cfg_alpha;
  logic [15:0] cfg_steps;

  outcome_t    expected_q [$];

  initial begin
    for (int i = 0; i < TABLE_N; i++) rules[i] = '0;
    for (int i = 0; i < STACK_DEPTH; i++) stk[i] = '0;
    sp = 0;
    cur = '0;
    halted = 1'b1;
    cfg_init_state = 4'd0;
    cfg_start_sym = 4'd1;
    cfg_final = 16'h0;
    cfg_alpha = 16'h0;
    cfg_steps = 16'd1024;
    fail_count = 0;
    pending = 0;
  end

  function automatic logic [3:0] top_sym();
    return (sp == 0) ? BLANK_CODE : stk[sp-1];
  endfunction

  // pop the top, then push; nothing changes on overflow
  function automatic bit apply_rule(rule_t r);
    int unsigned d;
    d = (sp > 0) ? sp - 1 : 0;
    if (d + r.count > STACK_DEPTH) return 1'b0;
    for (int i = 0; i < r.count; i++)
      stk[d+i] = (i < 4) ? r.syms[4*i +: 4] : 4'd0;
    sp = d + r.count;
    cur = r.next;
    return 1'b1;
  endfunction

  function automatic outcome_t run_automaton(logic [1:0] op, logic [3:0] sym);
    outcome_t    o;
    rule_t       r;
    int unsigned moves;
    logic [2:0]  st;
    st = ST_OK;
    moves = 0;
    if (op == OP_START) begin
      cur = cfg_init_state;
      stk[0] = cfg_start_sym;
      sp = 1;
      halted = 1'b0;
    end else if (halted) begin
      st = ST_STOPPED;
    end else if (op == OP_SYM && (sym == BLANK_CODE || !cfg_alpha[sym])) begin
      st = ST_BADSYM;
      halted = 1'b1;
    end else begin
      forever begin
        if (op == OP_END && cfg_final[cur]) begin
          st = ST_ACCEPT;
          break;
        end
        if (op == OP_SYM) begin
          r = rules[{cur, sym, top_sym()}];
          if (r.valid) begin
            if (!apply_rule(r)) st = ST_OVERFLOW;
            break;
          end
        end
        r = rules[{cur, BLANK_CODE, top_sym()}];
        if (!r.valid) begin
          st = ST_REJECT;
          break;
        end
        if (moves >= cfg_steps) begin
          st = ST_STEPLIM;
          break;
        end
        if (!apply_rule(r)) begin
          st = ST_OVERFLOW;
          break;
        end
        moves++;
      end
      if (st != ST_OK) halted = 1'b1;
    end
    o.status = st;
    o.state = cur;
    o.depth = sp[6:0];
    return o;
  endfunction

  always @(posedge clk) begin
    outcome_t exp_o;
    rule_t    nr;
    if (!rst) begin
      if (result.valid && result.ready) begin
        if (expected_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result: status %0d state %0d depth %0d",
                     result.status, result.state, result.stack_depth);
        end else begin
          exp_o = expected_q.pop_front();
          if (result.status !== exp_o.status || result.state !== exp_o.state ||
              result.stack_depth !== exp_o.depth) begin
            fail_count++;
            if (fail_count <= 10)
              $display("result mismatch: expected %0d/%0d/%0d got %0d/%0d/%0d",
                       exp_o.status, exp_o.state, exp_o.depth, result.status,
                       result.state, result.stack_depth);
          end
        end
      end
      if (item.valid && item.ready) begin
        if (item.op == OP_LOAD) begin
          nr.valid = item.rule_valid;
          nr.next = item.rule_next;
          nr.count = (item.rule_push_count > MAX_PUSH) ? 3'(MAX_PUSH) : item.rule_push_count;
          nr.syms = item.rule_push_symbols;
          rules[{item.rule_state, item.rule_input, item.rule_top}] = nr;
          exp_o.status = ST_OK;
          exp_o.state = cur;
          exp_o.depth = sp[6:0];
        end else begin
          exp_o = run_automaton(item.op, item.symbol);
        end
        expected_q.insert(expected_q.size(), exp_o);
      end
      pending = expected_q.size();
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_INIT_STATE: cfg_init_state = pwdata[3:0];
          REG_START_SYM:  cfg_start_sym = pwdata[3:0];
          REG_FINAL_MASK: cfg_final = pwdata[15:0];
          REG_ALPHA_MASK: cfg_alpha = pwdata[15:0];
          REG_STEP_LIMIT: cfg_steps = pwdata[15:0];
          default: ;
        endcase
      end
    end
  end

endmodule

// ----- dv/pushdown_automaton_recognizer_tb.sv -----
// ---------------------------------------------------------------------------
// pushdown_automaton_recognizer_tb
// Drives directed and random rule loads and strings into the recognizer with
// bursty requests and a stalling receiver, changes the registers between
// phases, and reports the verdict of the checker.
// ---------------------------------------------------------------------------
module pushdown_automaton_recognizer_tb;
  import pda_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count;
  int          pending;
  int          burst_left = 0;
  bit          hold_req = 1'b0;

  pda_item_if   item_ch ();
  pda_result_if res_ch ();

  pushdown_automaton_recognizer u_top (
    .clk(clk), .rst(rst), .item(item_ch.sink), .result(res_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  pda_checker u_checker (
    .clk(clk), .rst(rst), .item(item_ch), .result(res_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata), .fail_count(fail_count), .pending(pending)
  );

  always #2 clk = ~clk;

  initial begin
    #5ms;
    $display("pushdown_automaton_recognizer_tb: done, errors");
    $finish;
  end

  // receiver: random stalls in phases, one long hold-off on request
  initial begin
    int  mode;
    bit  held;
    held = 1'b0;
    mode = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        res_ch.ready <= 1'b0;
        for (int i = 0; i < 500; i++) @(posedge clk);
      end
      if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 2);
      case (mode)
        0: res_ch.ready <= 1'b1;
        1: res_ch.ready <= ($urandom_range(0, 3) != 0);
        default: res_ch.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic configure(logic [3:0] ss, logic [3:0] sym, logic [15:0] fm,
                           logic [15:0] am, logic [15:0] sl);
    reg_write(REG_INIT_STATE, 32'(ss));
    reg_write(REG_START_SYM, 32'(sym));
    reg_write(REG_FINAL_MASK, 32'(fm));
    reg_write(REG_ALPHA_MASK, 32'(am));
    reg_write(REG_STEP_LIMIT, 32'(sl));
  endtask

  // stop offering requests, then wait until every result has come back
  task automatic drain();
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic send(logic [1:0] op, logic [3:0] sym, logic [3:0] rs, logic [3:0] ri,
                      logic [3:0] rt, logic [3:0] rn, logic [2:0] pc, logic [15:0] ps,
                      logic rv);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = hold_req ? 0 : $urandom_range(0, 7);
      if (gap != 0) begin
        item_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    item_ch.valid <= 1'b1;
    item_ch.op <= op;
    item_ch.symbol <= sym;
    item_ch.rule_state <= rs;
    item_ch.rule_input <= ri;
    item_ch.rule_top <= rt;
    item_ch.rule_next <= rn;
    item_ch.rule_push_count <= pc;
    item_ch.rule_push_symbols <= ps;
    item_ch.rule_valid <= rv;
    do @(posedge clk); while (!item_ch.ready);
  endtask

  task automatic load(logic [3:0] rs, logic [3:0] ri, logic [3:0] rt, logic [3:0] rn,
                      logic [2:0] pc, logic [15:0] ps, logic rv);
    send(OP_LOAD, 4'd0, rs, ri, rt, rn, pc, ps, rv);
  endtask

  task automatic cmd(logic [1:0] op, logic [3:0] sym);
    send(op, sym, 4'($urandom), 4'($urandom), 4'($urandom), 4'($urandom),
         3'($urandom), 16'($urandom), 1'($urandom));
  endtask

  function automatic logic [3:0] small_code();
    return 4'($urandom_range(0, 3));
  endfunction

  initial begin
    int sent;
    int len;
    item_ch.valid = 1'b0;
    item_ch.op = OP_LOAD;
    item_ch.symbol = '0;
    item_ch.rule_state = '0;
    item_ch.rule_input = '0;
    item_ch.rule_top = '0;
    item_ch.rule_next = '0;
    item_ch.rule_push_count = '0;
    item_ch.rule_push_symbols = '0;
    item_ch.rule_valid = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: stopped, saturation, pop on blank, reject, accept, step limit
    configure(4'd2, 4'd15, 16'h0008, 16'hFFFE, 16'd1);
    cmd(OP_SYM, 4'd1);
    cmd(OP_END, 4'd0);
    load(4'd2, 4'd1, 4'd15, 4'd3, 3'd7, 16'h0FFF, 1'b1);
    load(4'd3, 4'd0, 4'd0, 4'd3, 3'd0, 16'h0000, 1'b1);
    load(4'd15, 4'd15, 4'd15, 4'd15, 3'd4, 16'hFFFF, 1'b1);
    cmd(OP_START, 4'd0);
    cmd(OP_SYM, 4'd1);
    cmd(OP_SYM, 4'd5);
    cmd(OP_SYM, 4'd1);
    cmd(OP_START, 4'd0);
    cmd(OP_SYM, 4'd0);
    cmd(OP_START, 4'd0);
    cmd(OP_END, 4'd0);
    cmd(OP_START, 4'd0);
    cmd(OP_SYM, 4'd1);
    cmd(OP_END, 4'd0);
    load(4'd3, 4'd0, 4'd15, 4'd3, 3'd1, 16'h000F, 1'b1);
    cmd(OP_START, 4'd0);
    cmd(OP_SYM, 4'd1);
    cmd(OP_SYM, 4'd5);
    load(4'd3, 4'd0, 4'd15, 4'd0, 3'd0, 16'h0000, 1'b0);
    load(4'd2, 4'd2, 4'd15, 4'd4, 3'd4, 16'h0000, 1'b1);
    load(4'd4, 4'd0, 4'd0, 4'd4, 3'd4, 16'h0000, 1'b1);
    drain();

    // blank chain that grows the stack until it overflows
    configure(4'd2, 4'd15, 16'h0000, 16'h0004, 16'hFFFF);
    cmd(OP_START, 4'd0);
    cmd(OP_SYM, 4'd2);
    cmd(OP_END, 4'd0);
    drain();

    // empty alphabet, every state accepting, start symbol blank
    configure(4'd15, 4'd0, 16'hFFFF, 16'h0000, 16'd1);
    cmd(OP_START, 4'd0);
    cmd(OP_SYM, 4'd3);
    cmd(OP_START, 4'd0);
    cmd(OP_END, 4'd0);
    drain();

    // random machines over a few states and symbols, strings of random content
    for (int round = 0; round < 6; round++) begin
      configure(small_code(), ($urandom_range(0, 4) == 0) ? 4'($urandom) : small_code(),
                16'($urandom), 16'($urandom) | 16'h000E,
                (round == 5) ? 16'd1 : 16'($urandom_range(1, 16)));
      sent = 0;
      for (int i = 0; i < 20; i++) begin
        load(small_code(), small_code(), small_code(), small_code(), 3'($urandom),
             ($urandom_range(0, 4) == 0) ? 16'($urandom) :
             {small_code(), small_code(), small_code(), small_code()},
             ($urandom_range(0, 7) != 0));
        sent++;
      end
      if (round == 1) hold_req = 1'b1;
      while (sent < 110) begin
        if ($urandom_range(0, 9) == 0) begin
          // noise: any op, any fields
          send(2'($urandom), 4'($urandom), 4'($urandom), 4'($urandom), 4'($urandom),
               4'($urandom), 3'($urandom), 16'($urandom), 1'($urandom));
          sent++;
        end else begin
          cmd(OP_START, 4'd0);
          len = $urandom_range(0, 10);
          for (int k = 0; k < len; k++)
            cmd(OP_SYM, ($urandom_range(0, 9) == 0) ? 4'($urandom) :
                4'($urandom_range(1, 3)));
          if ($urandom_range(0, 9) != 0) cmd(OP_END, 4'd0);
          sent += len + 2;
        end
      end
      drain();
    end

    if (fail_count == 0)
      $display("pushdown_automaton_recognizer_tb: done, clean");
    else
      $display("pushdown_automaton_recognizer_tb: done, errors");
    $finish;
  end

endmodule
